[rtl/kfs_pkg.sv]
// Shared types, constants and step functions for the key repeat frequency stepper.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package kfs_pkg;

  // Field widths
  localparam int unsigned FREQ_W     = 11;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Register reset values
  localparam logic [FREQ_W-1:0] INIT_FREQ_RST   = FREQ_W'(1012);
  localparam logic [FREQ_W-1:0] LOWER_RST       = FREQ_W'(870);
  localparam logic [FREQ_W-1:0] UPPER_RST       = FREQ_W'(1080);
  localparam logic [STEP_W-1:0] STEP_RST        = STEP_W'(2);
  localparam logic [CNT_W-1:0]  LONG_TICKS_RST  = CNT_W'(60000);
  localparam logic [CNT_W-1:0]  REPEAT_TICKS_RST = CNT_W'(30000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_FREQ    = 3'd0,
    REG_LOWER_BOUND  = 3'd1,
    REG_UPPER_BOUND  = 3'd2,
    REG_STEP_SIZE    = 3'd3,
    REG_LONG_TICKS   = 3'd4,
    REG_REPEAT_TICKS = 3'd5
  } cfg_reg_e;

  // Press machine states; code 3 is never entered
  typedef enum logic [1:0] {
    PS_IDLE   = 2'd0,
    PS_HELD   = 2'd1,
    PS_REPEAT = 2'd2
  } press_state_e;

  // One input beat, select_level in bit 0
  typedef struct packed {
    logic down_recheck;
    logic down_level;
    logic up_recheck;
    logic up_level;
    logic station_busy;
    logic enter_recheck;
    logic enter_level;
    logic select_recheck;
    logic select_level;
  } in_item_t;

  localparam int unsigned IN_ITEM_W = $bits(in_item_t);
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - FREQ_W - 4;

  // Key samples for one press machine
  typedef struct packed {
    logic level;
    logic recheck;
  } press_key_t;

  // Hold thresholds for the press machines
  typedef struct packed {
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } press_cfg_t;

  // Step up, clamped at the upper bound
  function automatic logic [FREQ_W-1:0] step_up(
    input logic [FREQ_W-1:0] f,
    input logic [STEP_W-1:0] step,
    input logic [FREQ_W-1:0] upper
  );
    logic [FREQ_W:0] sum;
    sum = {1'b0, f} + (FREQ_W + 1)'(step);
    if (sum > {1'b0, upper}) begin
      return upper;
    end
    return sum[FREQ_W-1:0];
  endfunction

  // Step down, clamped at the lower bound (also when it would go below zero)
  function automatic logic [FREQ_W-1:0] step_down(
    input logic [FREQ_W-1:0] f,
    input logic [STEP_W-1:0] step,
    input logic [FREQ_W-1:0] lower
  );
    logic [FREQ_W-1:0] diff;
    diff = f - FREQ_W'(step);
    if ((f < FREQ_W'(step)) || (diff < lower)) begin
      return lower;
    end
    return diff;
  endfunction

endpackage

[rtl/key_repeat_frequency_stepper.sv]
// Top level of the key repeat frequency stepper: stream ports, config registers, edit logic.
// Depends on kfs_pkg and kfs_press.

// One poll tick per beat. Each beat on the input stream yields exactly one result beat;
// the block takes a new beat every cycle unless back pressure holds it, and registers each
// result after its input is accepted (input register, then one pass through the select /
// enter / plus / minus logic into the result register). The rate is set by that single
// registered pass, which also updates the edit flag, the frequency, the snapshot and both
// press machines. Back pressure on the result side stalls the input side only once both
// registers hold a beat. Configuration writes are taken at any cycle (cfg_ready_o is always
// high) and must be issued only while no beat is in flight; writing initial_frequency also
// loads the current frequency. Writes to indexes beyond upper register 5 are ignored.
module key_repeat_frequency_stepper (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: select_level, select_recheck, enter_level, enter_recheck,
  // station_busy, up_level, up_recheck, down_level, down_recheck, zero pad
  input  logic [kfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: frequency[10:0], editing, conflict, committed, changed, zero pad
  output logic [kfs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kfs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned FW = kfs_pkg::FREQ_W;

  // Config registers
  logic [FW-1:0]                  lower_q, upper_q;
  logic [kfs_pkg::STEP_W-1:0]     step_q;
  kfs_pkg::press_cfg_t            press_cfg_q;

  // Block state
  logic [FW-1:0]                  cur_q, cur_d, snap_q, snap_d;
  logic                           edit_q, edit_d;

  // Pipeline
  logic                           in_valid_q, out_valid_q;
  kfs_pkg::in_item_t              in_q;
  logic                           advance;
  logic                           cfg_wr;

  // Result register
  logic [FW-1:0]                  out_freq_q;
  logic                           out_edit_q, out_conflict_q, out_commit_q, out_changed_q;

  // Tick logic
  logic                           sel_hit, edit_run, enter_hit, conflict, commit, changed;
  logic                           up_step, dn_step;
  logic [FW-1:0]                  freq_enter, freq_up;
  kfs_pkg::press_key_t            up_key, dn_key;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Handshake: the pass moves when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Select, then enter, then plus, then minus, all in one tick
  // (press machine steps count only on ticks that run the machines)
  always_comb begin
    sel_hit    = !in_q.select_level && !in_q.select_recheck;
    snap_d     = sel_hit ? cur_q : snap_q;
    edit_run   = edit_q || sel_hit;
    enter_hit  = edit_run && !in_q.enter_level && !in_q.enter_recheck;
    conflict   = enter_hit && in_q.station_busy;
    commit     = enter_hit && !in_q.station_busy;
    edit_d     = edit_run && !commit;
    freq_enter = conflict ? snap_d : cur_q;
    freq_up    = (edit_run && up_step) ?
                 kfs_pkg::step_up(freq_enter, step_q, upper_q) : freq_enter;
    cur_d      = (edit_run && dn_step) ?
                 kfs_pkg::step_down(freq_up, step_q, lower_q) : freq_up;
    changed    = sel_hit || enter_hit || (edit_run && (up_step || dn_step));
  end

  assign up_key = '{level: in_q.up_level, recheck: in_q.up_recheck};
  assign dn_key = '{level: in_q.down_level, recheck: in_q.down_recheck};

  // Press machines run only on ticks spent in edit mode
  kfs_press u_up_press (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance && edit_run),
    .key_i  (up_key),
    .cfg_i  (press_cfg_q),
    .step_o (up_step)
  );

  kfs_press u_dn_press (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance && edit_run),
    .key_i  (dn_key),
    .cfg_i  (press_cfg_q),
    .step_o (dn_step)
  );

  // Config registers; initial frequency write also reloads the current frequency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q                  <= kfs_pkg::LOWER_RST;
      upper_q                  <= kfs_pkg::UPPER_RST;
      step_q                   <= kfs_pkg::STEP_RST;
      press_cfg_q.long_ticks   <= kfs_pkg::LONG_TICKS_RST;
      press_cfg_q.repeat_ticks <= kfs_pkg::REPEAT_TICKS_RST;
    end else if (cfg_wr) begin
      case (kfs_pkg::cfg_reg_e'(cfg_index_i))
        kfs_pkg::REG_LOWER_BOUND:  lower_q <= cfg_data_i[FW-1:0];
        kfs_pkg::REG_UPPER_BOUND:  upper_q <= cfg_data_i[FW-1:0];
        kfs_pkg::REG_STEP_SIZE:    step_q  <= cfg_data_i[kfs_pkg::STEP_W-1:0];
        kfs_pkg::REG_LONG_TICKS:
          press_cfg_q.long_ticks <= cfg_data_i[kfs_pkg::CNT_W-1:0];
        kfs_pkg::REG_REPEAT_TICKS:
          press_cfg_q.repeat_ticks <= cfg_data_i[kfs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frequency, snapshot and edit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= kfs_pkg::INIT_FREQ_RST;
      snap_q <= '0;
      edit_q <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_index_i == kfs_pkg::REG_INIT_FREQ)) begin
        cur_q <= cfg_data_i[FW-1:0];
      end else if (advance) begin
        cur_q <= cur_d;
      end
      if (advance) begin
        snap_q <= snap_d;
        edit_q <= edit_d;
      end
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= kfs_pkg::in_item_t'(s_axis_tdata[kfs_pkg::IN_ITEM_W-1:0]);
    end
    if (advance) begin
      out_freq_q     <= cur_d;
      out_edit_q     <= edit_d;
      out_conflict_q <= conflict;
      out_commit_q   <= commit;
      out_changed_q  <= changed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{kfs_pkg::OUT_PAD_W{1'b0}}, out_changed_q, out_commit_q,
                          out_conflict_q, out_edit_q, out_freq_q};

endmodule

[rtl/kfs_press.sv]
// Press machine for one step key: idle, held, auto-repeat, with a hold counter.
// Depends on kfs_pkg for the state enum, key and threshold structs.
module kfs_press (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  kfs_pkg::press_key_t key_i,
  input  kfs_pkg::press_cfg_t cfg_i,
  output logic                step_o
);

  kfs_pkg::press_state_e      st_q, st_d, st_mid;
  logic [kfs_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_mid;

  // State and counter, advance only on ticks that run the machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= kfs_pkg::PS_IDLE;
      cnt_q <= '0;
    end else if (en_i) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // Next state: release steps a short press; holding counts up
  always_comb begin
    step_o  = 1'b0;
    st_mid  = st_q;
    cnt_mid = cnt_q;
    st_d    = st_q;
    cnt_d   = cnt_q;
    if (key_i.level) begin
      step_o = (st_q == kfs_pkg::PS_HELD);
      st_d   = kfs_pkg::PS_IDLE;
      cnt_d  = '0;
    end else begin
      // press is taken only if the recheck sample agrees
      if (st_q == kfs_pkg::PS_IDLE) begin
        st_mid = key_i.recheck ? kfs_pkg::PS_IDLE : kfs_pkg::PS_HELD;
      end
      if (st_mid == kfs_pkg::PS_HELD) begin
        cnt_mid = cnt_q + kfs_pkg::CNT_W'(1);
        if (cnt_mid > cfg_i.long_ticks) begin
          st_mid  = kfs_pkg::PS_REPEAT;
          cnt_mid = '0;
        end
      end
      st_d  = st_mid;
      cnt_d = cnt_mid;
      // auto-repeat: one step each time the count passes the interval
      if (st_mid == kfs_pkg::PS_REPEAT) begin
        cnt_d = cnt_mid + kfs_pkg::CNT_W'(1);
        if (cnt_d > cfg_i.repeat_ticks) begin
          cnt_d  = '0;
          step_o = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/kfs_checker.sv]
// Port-level checks for the key repeat frequency stepper, bound to the top level.
// Depends on kfs_pkg for port widths.
module kfs_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Enter is either rejected or accepted, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[12] && m_axis_tdata[13]))
    else $error("conflict and committed both set");

  // Enter outcome always refreshes the display
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[12] || m_axis_tdata[13]) |-> m_axis_tdata[14])
    else $error("enter outcome without changed");

  // A commit leaves edit mode, a conflict stays in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[13] || m_axis_tdata[12])
      |-> (m_axis_tdata[11] == m_axis_tdata[12]))
    else $error("edit flag wrong after enter");

  // An idle result side with nothing pending keeps the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |-> s_axis_tready)
    else $error("input stalled with empty pipeline");

endmodule

bind key_repeat_frequency_stepper kfs_port_checker u_kfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/kfs_checker.sv]
// Scoreboard for the key repeat frequency stepper: watches the key, result and register
// channels, keeps its own copy of the edit and press logic and compares each result beat.
// Depends on kfs_pkg for field widths, register indexes and press states.
`timescale 1ns / 100ps

module kfs_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // key beats into the block
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [kfs_pkg::IN_TDATA_W-1:0] in_data_i,
  // result beats out of the block
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [kfs_pkg::OUT_TDATA_W-1:0] out_data_i,
  // register writes
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // status toward the bench top
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    fail_count_o
);
  import kfs_pkg::*;

  localparam int KEY_UP   = 0;
  localparam int KEY_DOWN = 1;

  // One result beat, frequency in the low bits
  typedef struct packed {
    logic              changed;
    logic              committed;
    logic              conflict;
    logic              editing;
    logic [FREQ_W-1:0] freq;
  } tick_result_t;

  // Register copies
  logic [FREQ_W-1:0] init_freq_r, lower_r, upper_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  long_r, repeat_r;

  // Edit state and the two press machines
  logic [FREQ_W-1:0] cur_freq, snap_freq;
  logic              edit_on;
  press_state_e      key_st   [2];
  logic [CNT_W-1:0]  hold_cnt [2];

  tick_result_t tick_results_q [$];
  int unsigned  fails, checked;

  // Frequency after one step, clamped to the bound on that side
  function automatic logic [FREQ_W-1:0] stepped_freq(input bit up);
    int f;
    f = int'(cur_freq);
    if (up) begin
      f = f + int'(step_r);
      if (f > int'(upper_r)) f = int'(upper_r);
    end else begin
      f = f - int'(step_r);
      if (f < int'(lower_r)) f = int'(lower_r);
    end
    return FREQ_W'(f);
  endfunction

  // One poll tick of a press machine; returns 1 when the frequency stepped
  function automatic bit tick_key(input int k, input logic lvl, input logic rchk, input bit up);
    bit stepped;
    stepped = 1'b0;
    if (!lvl && key_st[k] == PS_IDLE) key_st[k] = rchk ? PS_IDLE : PS_HELD;
    if (lvl) begin
      if (key_st[k] == PS_HELD) begin
        cur_freq = stepped_freq(up);
        stepped  = 1'b1;
      end
      key_st[k]   = PS_IDLE;
      hold_cnt[k] = '0;
    end
    if (!lvl && key_st[k] == PS_HELD) hold_cnt[k] = hold_cnt[k] + 1'b1;
    if (key_st[k] == PS_HELD && hold_cnt[k] > long_r) begin
      key_st[k]   = PS_REPEAT;
      hold_cnt[k] = '0;
    end
    if (key_st[k] == PS_REPEAT && !lvl) begin
      hold_cnt[k] = hold_cnt[k] + 1'b1;
      if (hold_cnt[k] > repeat_r) begin
        hold_cnt[k] = '0;
        cur_freq    = stepped_freq(up);
        stepped     = 1'b1;
      end
    end
    return stepped;
  endfunction

  // Whole tick: select, then enter, then plus and minus
  function automatic tick_result_t predict_tick(input in_item_t it);
    tick_result_t r;
    r = '0;
    if (!it.select_level && !it.select_recheck) begin
      snap_freq = cur_freq;
      edit_on   = 1'b1;
      r.changed = 1'b1;
    end
    if (edit_on) begin
      if (!it.enter_level && !it.enter_recheck) begin
        if (it.station_busy) begin
          cur_freq   = snap_freq;
          r.conflict = 1'b1;
        end else begin
          r.committed = 1'b1;
          edit_on     = 1'b0;
        end
        r.changed = 1'b1;
      end
      if (tick_key(KEY_UP, it.up_level, it.up_recheck, 1'b1)) r.changed = 1'b1;
      if (tick_key(KEY_DOWN, it.down_level, it.down_recheck, 1'b0)) r.changed = 1'b1;
    end
    r.freq    = cur_freq;
    r.editing = edit_on;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    $display("%0t ns: result %0d %s mismatch, expected %0d, got %0d",
             $time, checked, what, want_v, got_v);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    tick_result_t want, got;
    if (!rst_ni) begin
      init_freq_r = INIT_FREQ_RST;
      lower_r     = LOWER_RST;
      upper_r     = UPPER_RST;
      step_r      = STEP_RST;
      long_r      = LONG_TICKS_RST;
      repeat_r    = REPEAT_TICKS_RST;
      cur_freq    = INIT_FREQ_RST;
      snap_freq   = '0;
      edit_on     = 1'b0;
      key_st[KEY_UP]     = PS_IDLE;
      key_st[KEY_DOWN]   = PS_IDLE;
      hold_cnt[KEY_UP]   = '0;
      hold_cnt[KEY_DOWN] = '0;
      tick_results_q.delete();
      fails   = 0;
      checked = 0;
      pending_o    <= 0;
      checked_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // register write; an unused index changes nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_INIT_FREQ: begin
            init_freq_r = cfg_data_i[FREQ_W-1:0];
            cur_freq    = init_freq_r;
          end
          REG_LOWER_BOUND:  lower_r  = cfg_data_i[FREQ_W-1:0];
          REG_UPPER_BOUND:  upper_r  = cfg_data_i[FREQ_W-1:0];
          REG_STEP_SIZE:    step_r   = cfg_data_i[STEP_W-1:0];
          REG_LONG_TICKS:   long_r   = cfg_data_i[CNT_W-1:0];
          REG_REPEAT_TICKS: repeat_r = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      // key beat in: queue what it should produce
      if (in_valid_i && in_ready_i)
        tick_results_q.push_back(predict_tick(in_data_i[IN_ITEM_W-1:0]));
      // result beat out: compare with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (tick_results_q.size() == 0) begin
          $display("%0t ns: result beat %h with nothing expected", $time, out_data_i);
          fails++;
        end else begin
          want = tick_results_q.pop_front();
          got  = out_data_i[FREQ_W+3:0];
          if (got.freq !== want.freq) note_mismatch("frequency", want.freq, got.freq);
          if (got.editing !== want.editing) note_mismatch("editing", want.editing, got.editing);
          if (got.conflict !== want.conflict)
            note_mismatch("conflict", want.conflict, got.conflict);
          if (got.committed !== want.committed)
            note_mismatch("committed", want.committed, got.committed);
          if (got.changed !== want.changed) note_mismatch("changed", want.changed, got.changed);
          if (out_data_i[OUT_TDATA_W-1:FREQ_W+4] !== '0)
            note_mismatch("pad", '0, out_data_i[OUT_TDATA_W-1:FREQ_W+4]);
        end
        checked++;
      end
      pending_o    <= tick_results_q.size();
      checked_o    <= checked;
      fail_count_o <= fails;
    end
  end

endmodule

[bench/tb_top.sv]
// Bench top for key_repeat_frequency_stepper: clock, reset, key and register stimulus,
// random idling on both stream sides, a stall watchdog and the verdict.
// Depends on kfs_pkg, the block under test and kfs_checker.
`timescale 1ns / 100ps

module tb_top;
  import kfs_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned PHASE_BEATS  = 204;
  localparam int unsigned DRAIN_CYCLES = 4;

  // indexes past the last register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // key sample pairs {level, recheck}
  localparam bit [1:0] KEY_REL = 2'b11;
  localparam bit [1:0] KEY_PRS = 2'b00;
  localparam bit [1:0] KEY_BNC = 2'b01;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int unsigned pending, checked, fail_count;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned key_beats      = 0;
  int unsigned cfg_writes     = 0;
  logic [CNT_W-1:0] long_now   = LONG_TICKS_RST;
  logic [CNT_W-1:0] repeat_now = REPEAT_TICKS_RST;

  key_repeat_frequency_stepper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  kfs_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .checked_o    (checked),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: too many cycles without any beat on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, pending);
    $display("FAIL key_repeat_frequency_stepper");
    $finish;
  end

  // one key beat, after a random number of idle cycles
  task automatic send_key_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    key_beats++;
  endtask

  function automatic in_item_t keys(input bit [1:0] sel, input bit [1:0] ent, input bit busy,
                                    input bit [1:0] up, input bit [1:0] dn);
    in_item_t it;
    it.select_level   = sel[1];
    it.select_recheck = sel[0];
    it.enter_level    = ent[1];
    it.enter_recheck  = ent[0];
    it.station_busy   = busy;
    it.up_level       = up[1];
    it.up_recheck     = up[0];
    it.down_level     = dn[1];
    it.down_recheck   = dn[0];
    return it;
  endfunction

  function automatic in_item_t released_keys();
    return keys(KEY_REL, KEY_REL, 1'($urandom_range(1)), KEY_REL, KEY_REL);
  endfunction

  // hold length: long enough to reach auto-repeat when the thresholds are small
  function automatic int unsigned hold_span();
    int unsigned reach;
    reach = (long_now <= 8 && repeat_now <= 8) ? long_now + 3 * repeat_now + 4 : 12;
    return $urandom_range(reach, 1);
  endfunction

  task automatic select_beats();
    in_item_t it;
    int unsigned n;
    n = ($urandom_range(3) == 0) ? 2 : 1;
    repeat (n) begin
      it = released_keys();
      it.select_level   = 1'b0;
      it.select_recheck = ($urandom_range(9) == 0);
      send_key_beat(it);
    end
  endtask

  task automatic enter_beat();
    in_item_t it;
    it = released_keys();
    it.enter_level   = 1'b0;
    it.enter_recheck = ($urandom_range(9) == 0);
    send_key_beat(it);
  endtask

  // plus, minus or both held for a while, with rare bounces, then released
  task automatic key_episode();
    int unsigned span, which;
    bit up_on, dn_on;
    in_item_t it;
    which = $urandom_range(9);
    up_on = (which <= 4) || (which == 9);
    dn_on = (which >= 5);
    span  = hold_span();
    for (int unsigned t = 0; t < span; t++) begin
      it = released_keys();
      if (up_on) begin
        it.up_level   = ($urandom_range(29) == 0);
        it.up_recheck = (t == 0) ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
      end
      if (dn_on) begin
        it.down_level   = ($urandom_range(29) == 0);
        it.down_recheck = (t == 0) ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
      end
      send_key_beat(it);
    end
    send_key_beat(released_keys());
  endtask

  task automatic run_traffic();
    int unsigned stop_at, pick;
    in_item_t it;
    logic [IN_ITEM_W-1:0] raw;
    stop_at = key_beats + PHASE_BEATS;
    while (key_beats < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        raw = $urandom();
        it  = raw;
        send_key_beat(it);
      end else if (pick < 22) begin
        select_beats();
      end else if (pick < 75) begin
        key_episode();
      end else if (pick < 88) begin
        enter_beat();
      end else begin
        send_key_beat(released_keys());
      end
    end
  endtask

  // stop sending and let every result come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v,
                           input int unsigned w);
    logic [31:0] keep;
    logic [CFG_DATA_W-1:0] d;
    keep = (32'h1 << w) - 1;
    d    = $urandom();
    d    = (d & ~keep[CFG_DATA_W-1:0]) | v;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
  endtask

  task automatic apply_settings(input int unsigned kind);
    logic [FREQ_W-1:0] f0, lo, hi;
    logic [STEP_W-1:0] st;
    logic [CNT_W-1:0]  lp, rp;
    case (kind)
      0: begin
        f0 = 1012; lo = 870; hi = 1080; st = 2; lp = 3; rp = 2;
      end
      1: begin
        f0 = 0; lo = 0; hi = 2047; st = 15; lp = 1; rp = 1;
      end
      2: begin
        // bounds crossed, thresholds never exceeded
        f0 = 2047; lo = 2047; hi = 0; st = 1; lp = 65535; rp = 65535;
      end
      default: begin
        f0 = $urandom_range(1080, 870);
        lo = $urandom_range(1100, 0);
        hi = $urandom_range(2047, 800);
        st = $urandom_range(15, 0);
        lp = $urandom_range(6, 0);
        rp = $urandom_range(4, 0);
      end
    endcase
    write_reg(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom(), 0);
    write_reg(REG_LOWER_BOUND, lo, FREQ_W);
    write_reg(REG_UPPER_BOUND, hi, FREQ_W);
    write_reg(REG_STEP_SIZE, st, STEP_W);
    write_reg(REG_LONG_TICKS, lp, CNT_W);
    write_reg(REG_REPEAT_TICKS, rp, CNT_W);
    write_reg(REG_INIT_FREQ, f0, FREQ_W);
    cfg_valid_i <= 1'b0;
    long_now   = lp;
    repeat_now = rp;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed beats at reset settings
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_REL));
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b1, KEY_PRS, KEY_PRS)); // frozen outside edit
    send_key_beat(keys(KEY_BNC, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // select bounce
    send_key_beat(keys(KEY_PRS, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // enter edit
    send_key_beat(keys(KEY_PRS, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // select held
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_PRS, KEY_REL));
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_PRS, KEY_REL));
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // short plus step
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_BNC)); // minus bounce
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_REL));
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_PRS));
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // short minus step
    send_key_beat(keys(KEY_REL, KEY_PRS, 1'b1, KEY_REL, KEY_REL)); // busy: restore
    send_key_beat(keys(KEY_REL, KEY_BNC, 1'b0, KEY_REL, KEY_REL)); // enter bounce
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_PRS, KEY_PRS));
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // both step
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_PRS, KEY_REL));
    send_key_beat(keys(KEY_REL, KEY_PRS, 1'b0, KEY_PRS, KEY_REL)); // commit, plus held
    send_key_beat(keys(KEY_REL, KEY_REL, 1'b0, KEY_REL, KEY_REL)); // release while frozen
    send_key_beat(keys(KEY_PRS, KEY_PRS, 1'b0, KEY_PRS, KEY_REL)); // select+enter commit
    send_key_beat(keys(KEY_PRS, KEY_PRS, 1'b1, KEY_REL, KEY_REL)); // select+enter busy
    send_key_beat(keys(KEY_REL, KEY_PRS, 1'b0, KEY_REL, KEY_REL));

    // random phases, each with its own settings and idling
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      drain();
      apply_settings((p + p / 4) % 4);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      run_traffic();
    end
    drain();

    $display("Sent %0d key beats over %0d setting phases with %0d register writes;",
             key_beats, PHASE_COUNT + 1, cfg_writes);
    $display("compared %0d result beats, %0d mismatches.", checked, fail_count);
    if (fail_count == 0)
      $display("PASS key_repeat_frequency_stepper");
    else
      $display("FAIL key_repeat_frequency_stepper");
    $finish;
  end

endmodule

[files.f]
rtl/kfs_pkg.sv
rtl/kfs_press.sv
rtl/key_repeat_frequency_stepper.sv
rtl/kfs_checker.sv
bench/kfs_checker.sv
bench/tb_top.sv
